// ===== sv/svom_pkg.sv =====
// shared constants, types and state codes for the sphere voxel occupancy marker
package svom_pkg;

    localparam int GRID_SIZE = 64;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 15;
    localparam int OUT_W   = 19;
    localparam int TGT_W   = 19;

    localparam logic [OUT_W-1:0] OUT_MAX = 19'h7FFFF;

    // wrapped cell index, span of one axis walk, row address of the bitmap
    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int SPAN_W = $clog2(GRID_SIZE + 1);
    localparam int ROWS   = GRID_SIZE * GRID_SIZE;
    localparam int ROW_W  = $clog2(ROWS);

    // coordinate and radius scaled by the grid
    localparam int CG_W = $clog2(65536 * GRID_SIZE);
    localparam int RG_W = $clog2(32768 * GRID_SIZE);

    // distance in units of 1/(2*GRID_SIZE*65536) of the box, and its squares
    localparam int D_W  = $clog2(3 * GRID_SIZE * 65536) + 1;
    localparam int SQ_W = 2 * D_W + 1;

    // occupancy counts
    localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int SAT_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    // square of one cell step in distance units
    localparam longint STEP_SQ = 64'd17179869184;

    // apb register word index
    localparam int APB_AW = 3;
    localparam logic REG_TARGET = 1'b0;

    typedef logic signed [D_W-1:0]  dist_t;
    typedef logic signed [SQ_W-1:0] sq_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_INIT,
        ST_SQUARE,
        ST_ROW_RD,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== sv/sphere_voxel_occupancy_marker.sv =====
// sphere voxel occupancy marker: walks a sphere's bounding cube over a row-wide bitmap memory
//
//  channel   dir  width  beat contents
//  s_axis    in   64     center_x, center_y, center_z, radius
//  m_axis    out  40     newly_marked, total_marked, target_reached
//  apb       in   32     occupancy_target at byte address 0
//
// each sphere walks (2*rc)^2 rows of 2*rc cells, rc = ceil(radius * GRID_SIZE / 65536);
//   a zero radius visits no cell. one row read per (x, y) pair, then one cell per cycle
//   along z against that row held in a register, written back on its last cell.
// after reset the bitmap is swept clear, one row a cycle over all GRID_SIZE^2 rows (4096),
//   during which no beat is taken on s_axis; apb writes are taken at all times.
// a finished result waits in the output register; the next sphere is taken meanwhile
//   and only stalls at the end of its walk if the previous result is still unclaimed.
module sphere_voxel_occupancy_marker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // apb configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [svom_pkg::APB_AW-1:0]           paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // sphere input: center_x [15:0], center_y [31:16], center_z [47:32], radius [62:48]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [63:0]                           s_tdata,
    // result: newly_marked [18:0], total_marked [37:19], target_reached [38]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [39:0]                           m_tdata
);

    localparam int G = svom_pkg::GRID_SIZE;

    svom_pkg::state_t state_reg, state_next;

    // configuration
    logic [svom_pkg::TGT_W-1:0] target_reg;
    logic                       cfg_wr;

    // sphere parameters
    logic [svom_pkg::COORD_W-1:0] c_reg   [3];
    logic [svom_pkg::RAD_W-1:0]   r_reg;
    logic [svom_pkg::CG_W-1:0]    cg_reg  [3];
    logic [svom_pkg::RG_W-1:0]    rg_reg;
    logic [svom_pkg::SPAN_W-1:0]  span_reg;
    svom_pkg::dist_t              d0_reg  [3];
    svom_pkg::dist_t              rr_reg;
    logic [svom_pkg::IDX_W-1:0]   w0_reg  [3];
    svom_pkg::sq_t                d0y2_reg;
    svom_pkg::sq_t                d0z2_reg;
    svom_pkg::sq_t                r2_reg;

    // walk state
    svom_pkg::dist_t              dx_reg, dy_reg, dz_reg;
    svom_pkg::sq_t                dx2_reg, dy2_reg, dz2_reg, dxy2_reg;
    logic [svom_pkg::IDX_W-1:0]   wx_reg, wy_reg, wz_reg;
    logic [svom_pkg::SPAN_W-1:0]  cntx_reg, cnty_reg, cntz_reg;
    logic                         first_reg;
    logic [G-1:0]                 row_reg;

    // counts and clearing sweep
    logic [svom_pkg::CNT_W-1:0]   fresh_reg, total_reg;
    logic [svom_pkg::ROW_W-1:0]   clr_reg;

    // output register
    logic                         m_tvalid_reg;
    logic [svom_pkg::OUT_W-1:0]   newly_reg, totalo_reg;
    logic                         reached_reg;

    // bitmap memory, one row of G cells per word
    logic [G-1:0]                 mem [svom_pkg::ROWS];
    logic [G-1:0]                 rdata_reg;
    logic                         mem_we, mem_re;
    logic [svom_pkg::ROW_W-1:0]   mem_waddr, row_addr;
    logic [G-1:0]                 mem_wdata;

    // setup arithmetic
    logic [svom_pkg::RG_W:0]      rc_sum;
    logic [svom_pkg::SPAN_W-1:0]  rc_calc;
    logic signed [2*svom_pkg::D_W-1:0] prod [3];
    logic signed [2*svom_pkg::D_W-1:0] prod_r;

    // cell test
    logic [G-1:0]                 cur_row, bit_mask, new_row;
    logic                         hit, mark;
    logic                         last_z, last_y, last_x;
    logic                         out_free;

    function automatic logic [svom_pkg::IDX_W-1:0] inc_wrap(
        input logic [svom_pkg::IDX_W-1:0] w
    );
        return (w == svom_pkg::IDX_W'(G - 1)) ? '0 : w + 1'b1;
    endfunction

    // first unwrapped index base - rc, taken modulo the grid
    function automatic logic [svom_pkg::IDX_W-1:0] start_wrap(
        input logic [svom_pkg::CG_W-1:0]   cg,
        input logic [svom_pkg::SPAN_W-1:0] rc
    );
        logic [svom_pkg::SPAN_W:0] w;
        w = (svom_pkg::SPAN_W+1)'(cg >> 16) + (svom_pkg::SPAN_W+1)'(G)
            - (svom_pkg::SPAN_W+1)'(rc);
        if (w >= (svom_pkg::SPAN_W+1)'(G)) begin
            w = w - (svom_pkg::SPAN_W+1)'(G);
        end
        return svom_pkg::IDX_W'(w);
    endfunction

    // distance of the first cell centre: (2*(base - rc) + 1) * 65536 - 2*G*c
    function automatic svom_pkg::dist_t start_dist(
        input logic [svom_pkg::CG_W-1:0]   cg,
        input logic [svom_pkg::SPAN_W-1:0] rc
    );
        svom_pkg::dist_t s;
        s = svom_pkg::D_W'(cg >> 16) - svom_pkg::D_W'(rc);
        return (((s <<< 1) + svom_pkg::D_W'(1)) <<< 16) - (svom_pkg::D_W'(cg) <<< 1);
    endfunction

    // square after one cell step: (d + 2^17)^2 = d^2 + d * 2^18 + 2^34
    function automatic svom_pkg::sq_t sq_step(
        input svom_pkg::sq_t   sq,
        input svom_pkg::dist_t d
    );
        return sq + (svom_pkg::SQ_W'(d) <<< 18) + svom_pkg::SQ_W'(svom_pkg::STEP_SQ);
    endfunction

    function automatic logic [svom_pkg::OUT_W-1:0] sat_out(
        input logic [svom_pkg::CNT_W-1:0] cnt
    );
        logic [svom_pkg::SAT_W-1:0] e;
        e = svom_pkg::SAT_W'(cnt);
        return (e > svom_pkg::SAT_W'(svom_pkg::OUT_MAX)) ? svom_pkg::OUT_MAX
                                                          : svom_pkg::OUT_W'(e);
    endfunction

    // ---------------------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == svom_pkg::REG_TARGET);
    assign prdata = (paddr[2] == svom_pkg::REG_TARGET)
                    ? {{(32 - svom_pkg::TGT_W){1'b0}}, target_reg} : 32'd0;

    // ---------------------------------------------------------------------------------
    // combinational datapath
    // ---------------------------------------------------------------------------------
    // cell-scaled radius rounded up
    assign rc_sum  = (svom_pkg::RG_W+1)'(rg_reg) + (svom_pkg::RG_W+1)'(65535);
    assign rc_calc = svom_pkg::SPAN_W'(rc_sum >> 16);

    // squares of the start distances and of the doubled radius, registered in the square state
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = d0_reg[k] * d0_reg[k];
        end
        prod_r = rr_reg * rr_reg;
    end

    assign row_addr = svom_pkg::ROW_W'(svom_pkg::ROW_W'(wx_reg) * svom_pkg::ROW_W'(G)
                      + svom_pkg::ROW_W'(wy_reg));

    // the row is read fresh on the first cell, then held in row_reg
    assign cur_row  = first_reg ? rdata_reg : row_reg;
    assign bit_mask = {{(G-1){1'b0}}, 1'b1} << wz_reg;
    assign hit      = (dxy2_reg + dz2_reg) < r2_reg;
    assign mark     = hit && ((cur_row & bit_mask) == '0);
    assign new_row  = mark ? (cur_row | bit_mask) : cur_row;

    assign last_z   = (cntz_reg == svom_pkg::SPAN_W'(1));
    assign last_y   = (cnty_reg == svom_pkg::SPAN_W'(1));
    assign last_x   = (cntx_reg == svom_pkg::SPAN_W'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------------------------
    // state machine
    // ---------------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svom_pkg::ST_CLEAR: begin
                if (clr_reg == svom_pkg::ROW_W'(svom_pkg::ROWS - 1)) begin
                    state_next = svom_pkg::ST_IDLE;
                end
            end
            svom_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = svom_pkg::ST_PREP;
                end
            end
            svom_pkg::ST_PREP: begin
                state_next = svom_pkg::ST_INIT;
            end
            svom_pkg::ST_INIT: begin
                // zero radius visits no cell
                state_next = (rc_calc == '0) ? svom_pkg::ST_DONE : svom_pkg::ST_SQUARE;
            end
            svom_pkg::ST_SQUARE: begin
                state_next = svom_pkg::ST_ROW_RD;
            end
            svom_pkg::ST_ROW_RD: begin
                state_next = svom_pkg::ST_WALK;
            end
            svom_pkg::ST_WALK: begin
                if (last_z) begin
                    state_next = (last_y && last_x) ? svom_pkg::ST_DONE
                                                    : svom_pkg::ST_ROW_RD;
                end
            end
            svom_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = svom_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // memory control and handshake outputs
    always_comb begin
        s_tready  = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = row_addr;
        mem_wdata = new_row;
        unique case (state_reg)
            svom_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            svom_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            svom_pkg::ST_ROW_RD: begin
                mem_re = 1'b1;
            end
            svom_pkg::ST_WALK: begin
                // write the row back on its last cell; the next read is a different row
                mem_we = last_z;
            end
            svom_pkg::ST_PREP, svom_pkg::ST_INIT, svom_pkg::ST_SQUARE,
            svom_pkg::ST_DONE: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // bitmap memory
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[row_addr];
        end
    end

    // ---------------------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= svom_pkg::ST_CLEAR;
            target_reg   <= '0;
            clr_reg      <= '0;
            fresh_reg    <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                target_reg <= pwdata[svom_pkg::TGT_W-1:0];
            end
            if (state_reg == svom_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (s_tvalid && s_tready) begin
                fresh_reg <= '0;
            end else if (state_reg == svom_pkg::ST_WALK && mark) begin
                fresh_reg <= fresh_reg + 1'b1;
                total_reg <= total_reg + 1'b1;
            end
            if (state_reg == svom_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (state_reg == svom_pkg::ST_DONE && out_free) begin
            newly_reg   <= sat_out(fresh_reg);
            totalo_reg  <= sat_out(total_reg);
            reached_reg <= svom_pkg::SAT_W'(total_reg) >= svom_pkg::SAT_W'(target_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, reached_reg, totalo_reg, newly_reg};

    // ---------------------------------------------------------------------------------
    // sphere setup and walk datapath
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            svom_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    c_reg[0] <= s_tdata[15:0];
                    c_reg[1] <= s_tdata[31:16];
                    c_reg[2] <= s_tdata[47:32];
                    r_reg    <= s_tdata[62:48];
                end
            end
            svom_pkg::ST_PREP: begin
                for (int k = 0; k < 3; k++) begin
                    cg_reg[k] <= svom_pkg::CG_W'(c_reg[k]) * svom_pkg::CG_W'(G);
                end
                rg_reg <= svom_pkg::RG_W'(r_reg) * svom_pkg::RG_W'(G);
            end
            svom_pkg::ST_INIT: begin
                for (int k = 0; k < 3; k++) begin
                    d0_reg[k] <= start_dist(cg_reg[k], rc_calc);
                    w0_reg[k] <= start_wrap(cg_reg[k], rc_calc);
                end
                rr_reg   <= svom_pkg::D_W'(rg_reg) <<< 1;
                span_reg <= rc_calc << 1;
            end
            svom_pkg::ST_SQUARE: begin
                dx_reg   <= d0_reg[0];
                dx2_reg  <= svom_pkg::SQ_W'(prod[0]);
                dy_reg   <= d0_reg[1];
                dy2_reg  <= svom_pkg::SQ_W'(prod[1]);
                d0y2_reg <= svom_pkg::SQ_W'(prod[1]);
                d0z2_reg <= svom_pkg::SQ_W'(prod[2]);
                r2_reg   <= svom_pkg::SQ_W'(prod_r);
                wx_reg   <= w0_reg[0];
                wy_reg   <= w0_reg[1];
                cntx_reg <= span_reg;
                cnty_reg <= span_reg;
            end
            svom_pkg::ST_ROW_RD: begin
                dxy2_reg  <= dx2_reg + dy2_reg;
                dz_reg    <= d0_reg[2];
                dz2_reg   <= d0z2_reg;
                wz_reg    <= w0_reg[2];
                cntz_reg  <= span_reg;
                first_reg <= 1'b1;
            end
            svom_pkg::ST_WALK: begin
                first_reg <= 1'b0;
                row_reg   <= new_row;
                if (!last_z) begin
                    cntz_reg <= cntz_reg - 1'b1;
                    dz_reg   <= dz_reg + svom_pkg::D_W'(131072);
                    dz2_reg  <= sq_step(dz2_reg, dz_reg);
                    wz_reg   <= inc_wrap(wz_reg);
                end else if (!last_y) begin
                    cnty_reg <= cnty_reg - 1'b1;
                    dy_reg   <= dy_reg + svom_pkg::D_W'(131072);
                    dy2_reg  <= sq_step(dy2_reg, dy_reg);
                    wy_reg   <= inc_wrap(wy_reg);
                end else if (!last_x) begin
                    cntx_reg <= cntx_reg - 1'b1;
                    dx_reg   <= dx_reg + svom_pkg::D_W'(131072);
                    dx2_reg  <= sq_step(dx2_reg, dx_reg);
                    wx_reg   <= inc_wrap(wx_reg);
                    cnty_reg <= span_reg;
                    dy_reg   <= d0_reg[1];
                    dy2_reg  <= d0y2_reg;
                    wy_reg   <= w0_reg[1];
                end
            end
            svom_pkg::ST_CLEAR, svom_pkg::ST_DONE: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == svom_pkg::ST_CLEAR || state_reg == svom_pkg::ST_WALK))
        else $error("bitmap written outside clearing sweep or walk");

    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svom_pkg::ST_CLEAR) |-> !s_tready)
        else $error("sphere beat taken during clearing sweep");

    a_fresh_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= total_reg)
        else $error("newly marked count above running total");

    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> total_reg >= $past(total_reg))
        else $error("running total went down");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svom_pkg::ST_DONE && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("finished sphere did not reach the output register");

endmodule
